// File: hw/rtl/stip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stip_pkg
// Shared types and constants for the sorted table insert position block.
// ----------------------------------------------------------------------------
package stip_pkg;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int KEY_W           = 32;
  localparam int POS_W           = 11;

  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_SEARCH = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef struct packed {
    logic [1:0]              func;
    logic signed [KEY_W-1:0] key_value;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             status;
  } out_item_t;

endpackage

// File: hw/rtl/sorted_table_insert_position.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_insert_position
// Table of signed values the user must append in ascending order (unchecked),
// with a lower-bound binary search that gives the insertion position of a key.
// ----------------------------------------------------------------------------
// Append, clear and unknown items finish in the cycle they are accepted and
// show their result in the next cycle. A search runs through the single
// read port of the table memory: each halving step reads the middle entry,
// then compares it and updates a bound; an empty table goes straight to the
// result. One item is worked on at a time; the next is taken once the output
// register is empty or is read out in that cycle. The table memory has no
// reset; only entries below the entry count are compared.
module sorted_table_insert_position #(
  parameter int TABLE_DEPTH = stip_pkg::DEF_TABLE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  stip_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output stip_pkg::out_item_t out_data
);
  import stip_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_CMP  = 3'b100
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [CW-1:0]           lo_r, lo_nxt;
  logic [CW-1:0]           hi_r, hi_nxt;
  logic [CW-1:0]           mid_r, mid_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_data_r, out_data_nxt;

  logic signed [KEY_W-1:0] mem [TABLE_DEPTH];
  logic signed [KEY_W-1:0] rd_data_r;
  logic [CW-1:0]           mid;
  logic                    in_accept;
  logic                    wr_en;
  logic                    full;
  logic [XW-1:0]           pos_wide;

  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_accept = in_valid && !in_stall;
  assign full      = (count_r == CW'(TABLE_DEPTH));
  assign mid       = lo_r + ((hi_r - lo_r) >> 1);
  assign wr_en     = in_accept && (in_data.func == FUNC_APPEND) && !full;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    pos_wide      = XW'(count_r);
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          case (in_data.func)
            FUNC_APPEND: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_data_nxt.status = 1'b1;
              end else begin
                count_nxt           = count_r + CW'(1);
                pos_wide            = XW'(count_nxt);
                out_data_nxt.status = 1'b0;
              end
              out_data_nxt.position = pos_wide[POS_W-1:0];
            end
            FUNC_SEARCH: begin
              lo_nxt    = '0;
              hi_nxt    = count_r;
              key_nxt   = in_data.key_value;
              state_nxt = S_READ;
            end
            FUNC_CLEAR: begin
              count_nxt             = '0;
              out_valid_nxt         = 1'b1;
              out_data_nxt.position = '0;
              out_data_nxt.status   = 1'b0;
            end
            default: begin
              out_valid_nxt         = 1'b1;
              out_data_nxt.position = pos_wide[POS_W-1:0];
              out_data_nxt.status   = 1'b0;
            end
          endcase
        end
      end
      S_READ: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid;
          state_nxt = S_CMP;
        end else begin
          pos_wide              = XW'(lo_r);
          out_valid_nxt         = 1'b1;
          out_data_nxt.position = pos_wide[POS_W-1:0];
          out_data_nxt.status   = 1'b0;
          state_nxt             = S_IDLE;
        end
      end
      S_CMP: begin
        if (rd_data_r < key_r) begin
          lo_nxt = mid_r + CW'(1);
        end else begin
          hi_nxt = mid_r;
        end
        state_nxt = S_READ;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    key_r      <= key_nxt;
    out_data_r <= out_data_nxt;
  end

  // table memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[AW-1:0]] <= in_data.key_value;
    end
    rd_data_r <= mem[mid[AW-1:0]];
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (lo_r <= hi_r) && (hi_r <= count_r))
    else $error("search bounds out of order");

  a_mid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (mid_r >= lo_r) && (mid_r < hi_r))
    else $error("middle index outside search window");

  a_search_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) && !(lo_r < hi_r) |=> out_valid_r && (state_r == S_IDLE))
    else $error("finished search did not post a result");

endmodule
